// ===== rtl/uf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package uf_pkg;

    // fixed field widths of the item and result
    localparam int unsigned CMD_W      = 2;
    localparam int unsigned IDX_IN_W   = 10;
    localparam int unsigned SIZE_OUT_W = 11;
    localparam int unsigned CNT_OUT_W  = 11;
    localparam int unsigned CFG_W      = 11;

    // stream packing
    localparam int unsigned IN_DATA_W  = 24;
    localparam int unsigned IN_PAD_W   = 2;
    localparam int unsigned OUT_DATA_W = 48;
    localparam int unsigned OUT_PAD_W  = 3;

    // node count after reset
    localparam int unsigned CFG_RESET  = 1024;

    typedef enum logic [CMD_W-1:0] {
        CMD_UNITE = 2'd0,
        CMD_QUERY = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [9:0] {
        ST_CLEAR    = 10'b00_0000_0001,
        ST_IDLE     = 10'b00_0000_0010,
        ST_CHECK    = 10'b00_0000_0100,
        ST_FIND_RD  = 10'b00_0000_1000,
        ST_FIND_CMP = 10'b00_0001_0000,
        ST_COMPRESS = 10'b00_0010_0000,
        ST_SAME     = 10'b00_0100_0000,
        ST_SIZE_A   = 10'b00_1000_0000,
        ST_SIZE_B   = 10'b01_0000_0000,
        ST_RESULT   = 10'b10_0000_0000
    } state_t;

    typedef struct packed {
        logic merged;
        logic same_set;
        logic error;
    } res_flags_t;

endpackage

`default_nettype wire

// ===== rtl/uf_alu.sv =====
`timescale 1ns / 1ps
`default_nettype none

module uf_alu #(
    parameter int unsigned W = 11
) (
    input  wire logic [W-1:0] op_x,
    input  wire logic [W-1:0] op_y,
    output logic              eq,
    output logic              ge,
    output logic [W-1:0]      sum
);

    // one shared compare and add
    assign eq  = (op_x == op_y);
    assign ge  = (op_x >= op_y);
    assign sum = op_x + op_y;

endmodule

`default_nettype wire

// ===== rtl/uf_tables.sv =====
`timescale 1ns / 1ps
`default_nettype none

module uf_tables #(
    parameter int unsigned NODES  = 1024,
    parameter int unsigned NODE_W = 10,
    parameter int unsigned CNT_W  = 11
) (
    input  wire logic              aclk,
    input  wire logic [NODE_W-1:0] link_raddr,
    output logic      [NODE_W-1:0] link_rdata,
    input  wire logic              link_we,
    input  wire logic [NODE_W-1:0] link_waddr,
    input  wire logic [NODE_W-1:0] link_wdata,
    input  wire logic [NODE_W-1:0] size_raddr,
    output logic      [CNT_W-1:0]  size_rdata,
    input  wire logic              size_we,
    input  wire logic [NODE_W-1:0] size_waddr,
    input  wire logic [CNT_W-1:0]  size_wdata
);

    logic [NODE_W-1:0] link_mem [NODES];
    logic [CNT_W-1:0]  size_mem [NODES];
    logic [NODE_W-1:0] link_rdata_reg;
    logic [CNT_W-1:0]  size_rdata_reg;

    // parent links
    always_ff @(posedge aclk) begin
        if (link_we) begin
            link_mem[link_waddr] <= link_wdata;
        end
        link_rdata_reg <= link_mem[link_raddr];
    end

    // set sizes, meaningful at roots
    always_ff @(posedge aclk) begin
        if (size_we) begin
            size_mem[size_waddr] <= size_wdata;
        end
        size_rdata_reg <= size_mem[size_raddr];
    end

    assign link_rdata = link_rdata_reg;
    assign size_rdata = size_rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/uf_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module uf_ctrl #(
    parameter int unsigned NODES      = 1024,
    parameter int unsigned PATH_DEPTH = 11
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [uf_pkg::CMD_W-1:0]    in_cmd,
    input  wire logic [uf_pkg::IDX_IN_W-1:0] in_node_a,
    input  wire logic [uf_pkg::IDX_IN_W-1:0] in_node_b,
    input  wire logic [uf_pkg::CFG_W-1:0]    cfg_count,
    output logic                             res_valid,
    input  wire logic                        res_ready,
    output logic [$clog2(NODES)-1:0]         res_root_a,
    output logic [$clog2(NODES)-1:0]         res_root_b,
    output logic [$clog2(NODES+1)-1:0]       res_size,
    output logic [$clog2(NODES+1)-1:0]       res_count,
    output uf_pkg::res_flags_t               res_flags
);

    localparam int unsigned NODE_W = $clog2(NODES);
    localparam int unsigned CNT_W  = $clog2(NODES + 1);
    localparam int unsigned DEP_W  = $clog2(PATH_DEPTH + 1);
    localparam int unsigned PIDX_W = $clog2(PATH_DEPTH);
    localparam int unsigned CMP_A  = (CNT_W > uf_pkg::IDX_IN_W) ? CNT_W : uf_pkg::IDX_IN_W;
    localparam int unsigned CMP_W  = (CMP_A > uf_pkg::CFG_W) ? CMP_A : uf_pkg::CFG_W;
    localparam int unsigned RESET_COUNT_I =
        (uf_pkg::CFG_RESET > NODES) ? NODES : uf_pkg::CFG_RESET;
    localparam logic [CNT_W-1:0] RESET_COUNT = CNT_W'(RESET_COUNT_I);

    uf_pkg::state_t      state_reg, state_next;
    uf_pkg::cmd_t        cmd_reg, cmd_next;
    logic [uf_pkg::IDX_IN_W-1:0] node_a_reg, node_a_next;
    logic [uf_pkg::IDX_IN_W-1:0] node_b_reg, node_b_next;
    logic [NODE_W-1:0]   cur_reg, cur_next;
    logic [DEP_W-1:0]    depth_reg, depth_next;
    logic [DEP_W-1:0]    cidx_reg, cidx_next;
    logic                phase_b_reg, phase_b_next;
    logic [NODE_W-1:0]   ra_reg, ra_next;
    logic [NODE_W-1:0]   rb_reg, rb_next;
    logic [CNT_W-1:0]    size_a_reg, size_a_next;
    logic [CNT_W-1:0]    size_res_reg, size_res_next;
    logic                merged_reg, merged_next;
    logic                same_reg, same_next;
    logic                err_reg, err_next;
    logic [CNT_W-1:0]    active_reg, active_next;
    logic [CNT_W-1:0]    sets_reg, sets_next;
    logic [NODE_W-1:0]   sweep_reg, sweep_next;
    logic                clr_reply_reg, clr_reply_next;
    logic [NODE_W-1:0]   path_buf_reg [PATH_DEPTH];

    logic                push_en;
    logic [CMP_W-1:0]    cfg_ext;
    logic [CNT_W-1:0]    cfg_clamped;
    logic                range_err;
    logic [NODE_W-1:0]   root_cur;

    logic [CNT_W-1:0]    alu_x, alu_y, alu_sum;
    logic                alu_eq, alu_ge;

    logic [NODE_W-1:0]   link_raddr, link_rdata, link_waddr, link_wdata;
    logic                link_we;
    logic [NODE_W-1:0]   size_raddr, size_waddr;
    logic [CNT_W-1:0]    size_rdata, size_wdata;
    logic                size_we;

    uf_alu #(
        .W (CNT_W)
    ) u_alu (
        .op_x (alu_x),
        .op_y (alu_y),
        .eq   (alu_eq),
        .ge   (alu_ge),
        .sum  (alu_sum)
    );

    uf_tables #(
        .NODES  (NODES),
        .NODE_W (NODE_W),
        .CNT_W  (CNT_W)
    ) u_tables (
        .aclk       (aclk),
        .link_raddr (link_raddr),
        .link_rdata (link_rdata),
        .link_we    (link_we),
        .link_waddr (link_waddr),
        .link_wdata (link_wdata),
        .size_raddr (size_raddr),
        .size_rdata (size_rdata),
        .size_we    (size_we),
        .size_waddr (size_waddr),
        .size_wdata (size_wdata)
    );

    // saturate the configured count into the supported range
    always_comb begin
        cfg_ext = CMP_W'(cfg_count);
        priority if (cfg_ext < CMP_W'(2)) begin
            cfg_clamped = CNT_W'(2);
        end else if (cfg_ext > CMP_W'(NODES)) begin
            cfg_clamped = CNT_W'(NODES);
        end else begin
            cfg_clamped = CNT_W'(cfg_ext);
        end
    end

    assign range_err = (CMP_W'(node_a_reg) >= CMP_W'(active_reg)) ||
                       (CMP_W'(node_b_reg) >= CMP_W'(active_reg));
    assign root_cur  = phase_b_reg ? rb_reg : ra_reg;

    // sequencer
    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        node_a_next    = node_a_reg;
        node_b_next    = node_b_reg;
        cur_next       = cur_reg;
        depth_next     = depth_reg;
        cidx_next      = cidx_reg;
        phase_b_next   = phase_b_reg;
        ra_next        = ra_reg;
        rb_next        = rb_reg;
        size_a_next    = size_a_reg;
        size_res_next  = size_res_reg;
        merged_next    = merged_reg;
        same_next      = same_reg;
        err_next       = err_reg;
        active_next    = active_reg;
        sets_next      = sets_reg;
        sweep_next     = sweep_reg;
        clr_reply_next = clr_reply_reg;

        push_en    = 1'b0;
        in_ready   = 1'b0;
        res_valid  = 1'b0;
        alu_x      = '0;
        alu_y      = '0;
        link_raddr = cur_reg;
        link_we    = 1'b0;
        link_waddr = '0;
        link_wdata = '0;
        size_raddr = ra_reg;
        size_we    = 1'b0;
        size_waddr = '0;
        size_wdata = '0;

        unique case (state_reg)
            // rebuild every entry, one per cycle
            uf_pkg::ST_CLEAR: begin
                link_we    = 1'b1;
                link_waddr = sweep_reg;
                link_wdata = sweep_reg;
                size_we    = 1'b1;
                size_waddr = sweep_reg;
                size_wdata = CNT_W'(1);
                sweep_next = sweep_reg + NODE_W'(1);
                if (sweep_reg == NODE_W'(NODES - 1)) begin
                    sweep_next = '0;
                    state_next = clr_reply_reg ? uf_pkg::ST_RESULT : uf_pkg::ST_IDLE;
                end
            end

            uf_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd_next      = uf_pkg::cmd_t'(in_cmd);
                    node_a_next   = in_node_a;
                    node_b_next   = in_node_b;
                    ra_next       = '0;
                    rb_next       = '0;
                    size_res_next = '0;
                    merged_next   = 1'b0;
                    same_next     = 1'b0;
                    err_next      = 1'b0;
                    unique case (uf_pkg::cmd_t'(in_cmd))
                        uf_pkg::CMD_UNITE, uf_pkg::CMD_QUERY: begin
                            state_next = uf_pkg::ST_CHECK;
                        end
                        uf_pkg::CMD_CLEAR: begin
                            active_next    = cfg_clamped;
                            sets_next      = cfg_clamped;
                            clr_reply_next = 1'b1;
                            sweep_next     = '0;
                            state_next     = uf_pkg::ST_CLEAR;
                        end
                        uf_pkg::CMD_NOP: begin
                            state_next = uf_pkg::ST_RESULT;
                        end
                        default: begin
                            state_next = uf_pkg::ST_RESULT;
                        end
                    endcase
                end
            end

            // range check against the count latched at the last clear
            uf_pkg::ST_CHECK: begin
                if (range_err) begin
                    err_next   = 1'b1;
                    state_next = uf_pkg::ST_RESULT;
                end else begin
                    cur_next     = NODE_W'(node_a_reg);
                    depth_next   = '0;
                    phase_b_next = 1'b0;
                    state_next   = uf_pkg::ST_FIND_RD;
                end
            end

            uf_pkg::ST_FIND_RD: begin
                link_raddr = cur_reg;
                state_next = uf_pkg::ST_FIND_CMP;
            end

            // one link per cycle: the next read is issued from the data just read
            uf_pkg::ST_FIND_CMP: begin
                alu_x = CNT_W'(link_rdata);
                alu_y = CNT_W'(cur_reg);
                if (alu_eq) begin
                    if (phase_b_reg) begin
                        rb_next = cur_reg;
                    end else begin
                        ra_next = cur_reg;
                    end
                    if (depth_reg != '0) begin
                        cidx_next  = '0;
                        state_next = uf_pkg::ST_COMPRESS;
                    end else if (!phase_b_reg) begin
                        phase_b_next = 1'b1;
                        cur_next     = NODE_W'(node_b_reg);
                        state_next   = uf_pkg::ST_FIND_RD;
                    end else begin
                        state_next = uf_pkg::ST_SAME;
                    end
                end else begin
                    if (depth_reg < DEP_W'(PATH_DEPTH)) begin
                        push_en    = 1'b1;
                        depth_next = depth_reg + DEP_W'(1);
                    end
                    cur_next   = link_rdata;
                    link_raddr = link_rdata;
                end
            end

            // point every buffered node straight at the root
            uf_pkg::ST_COMPRESS: begin
                link_we    = 1'b1;
                link_waddr = path_buf_reg[cidx_reg[PIDX_W-1:0]];
                link_wdata = root_cur;
                cidx_next  = cidx_reg + DEP_W'(1);
                if (cidx_reg == depth_reg - DEP_W'(1)) begin
                    if (!phase_b_reg) begin
                        phase_b_next = 1'b1;
                        cur_next     = NODE_W'(node_b_reg);
                        depth_next   = '0;
                        state_next   = uf_pkg::ST_FIND_RD;
                    end else begin
                        state_next = uf_pkg::ST_SAME;
                    end
                end
            end

            uf_pkg::ST_SAME: begin
                alu_x      = CNT_W'(ra_reg);
                alu_y      = CNT_W'(rb_reg);
                same_next  = alu_eq;
                size_raddr = ra_reg;
                state_next = uf_pkg::ST_SIZE_A;
            end

            uf_pkg::ST_SIZE_A: begin
                size_a_next = size_rdata;
                if (cmd_reg == uf_pkg::CMD_UNITE && !same_reg) begin
                    size_raddr = rb_reg;
                    state_next = uf_pkg::ST_SIZE_B;
                end else begin
                    size_res_next = size_rdata;
                    state_next    = uf_pkg::ST_RESULT;
                end
            end

            // link the smaller set under the larger, first root wins a tie
            uf_pkg::ST_SIZE_B: begin
                alu_x      = size_a_reg;
                alu_y      = size_rdata;
                link_we    = 1'b1;
                size_we    = 1'b1;
                size_wdata = alu_sum;
                if (alu_ge) begin
                    link_waddr = rb_reg;
                    link_wdata = ra_reg;
                    size_waddr = ra_reg;
                    rb_next    = ra_reg;
                end else begin
                    link_waddr = ra_reg;
                    link_wdata = rb_reg;
                    size_waddr = rb_reg;
                    ra_next    = rb_reg;
                end
                size_res_next = alu_sum;
                merged_next   = 1'b1;
                if (sets_reg != '0) begin
                    sets_next = sets_reg - CNT_W'(1);
                end
                state_next = uf_pkg::ST_RESULT;
            end

            uf_pkg::ST_RESULT: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    clr_reply_next = 1'b0;
                    state_next     = uf_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = uf_pkg::ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= uf_pkg::ST_CLEAR;
            cmd_reg       <= uf_pkg::CMD_NOP;
            phase_b_reg   <= 1'b0;
            depth_reg     <= '0;
            cidx_reg      <= '0;
            active_reg    <= RESET_COUNT;
            sets_reg      <= RESET_COUNT;
            sweep_reg     <= '0;
            clr_reply_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            phase_b_reg   <= phase_b_next;
            depth_reg     <= depth_next;
            cidx_reg      <= cidx_next;
            active_reg    <= active_next;
            sets_reg      <= sets_next;
            sweep_reg     <= sweep_next;
            clr_reply_reg <= clr_reply_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        node_a_reg   <= node_a_next;
        node_b_reg   <= node_b_next;
        cur_reg      <= cur_next;
        ra_reg       <= ra_next;
        rb_reg       <= rb_next;
        size_a_reg   <= size_a_next;
        size_res_reg <= size_res_next;
        merged_reg   <= merged_next;
        same_reg     <= same_next;
        err_reg      <= err_next;
    end

    // visited nodes of the current find
    always_ff @(posedge aclk) begin
        if (push_en) begin
            path_buf_reg[depth_reg[PIDX_W-1:0]] <= cur_reg;
        end
    end

    assign res_root_a         = ra_reg;
    assign res_root_b         = rb_reg;
    assign res_size           = size_res_reg;
    assign res_count          = sets_reg;
    assign res_flags.merged   = merged_reg;
    assign res_flags.same_set = same_reg;
    assign res_flags.error    = err_reg;

endmodule

`default_nettype wire

// ===== rtl/union_find_engine_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  width  fields (lowest bit up)
// s_axis    in   24     command[1:0] node_a[11:2] node_b[21:12]
// m_axis    out  48     root_a root_b merged same_set set_size set_count error
// cfg       in   11     elements_in_use, write only
//
// unite and query walk the links of node_a and compress that path, then do the same
// for node_b; a merging unite then adds one link write and one size write;
// one link read per cycle, one write per cycle for compression
// clear runs the sweep over all NODES entries, writing one entry per cycle
// after reset the same full-table sweep runs and no item is accepted meanwhile
// s_axis_tready is high only between items; a result waits in the output
// register while the next item is accepted, and the engine holds if it is
// still full when the next result is ready
module union_find_engine_unit #(
    parameter int unsigned NODES      = 1024,
    parameter int unsigned PATH_DEPTH = 11
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // command, node_a, node_b
    input  wire logic [uf_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // root_a, root_b, merged, same_set, set_size, set_count, error
    output logic [uf_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    input  wire logic                           cfg_wr_en,
    input  wire logic [uf_pkg::CFG_W-1:0]       cfg_wr_data
);

    localparam int unsigned NODE_W = $clog2(NODES);
    localparam int unsigned CNT_W  = $clog2(NODES + 1);

    logic [uf_pkg::CFG_W-1:0]      cfg_reg;
    logic                          m_valid_reg, m_valid_next;
    logic [uf_pkg::IDX_IN_W-1:0]   m_root_a_reg, m_root_b_reg;
    logic [uf_pkg::SIZE_OUT_W-1:0] m_size_reg;
    logic [uf_pkg::CNT_OUT_W-1:0]  m_count_reg;
    logic                          m_merged_reg, m_same_reg, m_error_reg;

    logic                          res_valid, res_ready, res_take;
    logic [NODE_W-1:0]             res_root_a, res_root_b;
    logic [CNT_W-1:0]              res_size, res_count;
    uf_pkg::res_flags_t            res_flags;

    uf_ctrl #(
        .NODES      (NODES),
        .PATH_DEPTH (PATH_DEPTH)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_cmd     (s_axis_tdata[uf_pkg::CMD_W-1:0]),
        .in_node_a  (s_axis_tdata[uf_pkg::CMD_W +: uf_pkg::IDX_IN_W]),
        .in_node_b  (s_axis_tdata[uf_pkg::CMD_W + uf_pkg::IDX_IN_W +: uf_pkg::IDX_IN_W]),
        .cfg_count  (cfg_reg),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_root_a (res_root_a),
        .res_root_b (res_root_b),
        .res_size   (res_size),
        .res_count  (res_count),
        .res_flags  (res_flags)
    );

    // node count register, applied by the next clear
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= uf_pkg::CFG_W'(uf_pkg::CFG_RESET);
        end else if (cfg_wr_en) begin
            cfg_reg <= cfg_wr_data;
        end
    end

    // output register
    assign res_ready = !m_valid_reg || m_axis_tready;
    assign res_take  = res_valid && res_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_take) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_take) begin
            m_root_a_reg <= uf_pkg::IDX_IN_W'(res_root_a);
            m_root_b_reg <= uf_pkg::IDX_IN_W'(res_root_b);
            m_size_reg   <= uf_pkg::SIZE_OUT_W'(res_size);
            m_count_reg  <= uf_pkg::CNT_OUT_W'(res_count);
            m_merged_reg <= res_flags.merged;
            m_same_reg   <= res_flags.same_set;
            m_error_reg  <= res_flags.error;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{uf_pkg::OUT_PAD_W{1'b0}}, m_error_reg, m_count_reg, m_size_reg,
                            m_same_reg, m_merged_reg, m_root_b_reg, m_root_a_reg};

    // an accepted item leaves the engine not ready in the following cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("engine ready right after accepting an item");

    // a merge leaves both nodes under one root
    a_merge_one_root: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_merged_reg |-> m_root_a_reg == m_root_b_reg)
        else $error("merged result with two different roots");

    // an out of range item reports nothing but the count
    a_error_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_error_reg |-> !m_merged_reg && !m_same_reg && m_size_reg == '0)
        else $error("error result carries set data");

    // at least one set always remains
    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_count_reg != '0)
        else $error("set count dropped to zero");

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int unsigned NODE_CAP     = 1024;
    localparam int unsigned PATH_LEN     = 11;
    localparam int unsigned LIMIT_CYCLES = 900000;
    localparam int unsigned MAX_REPORTS  = 10;

    typedef struct packed {
        logic [9:0]  root_a;
        logic [9:0]  root_b;
        logic        merged;
        logic        same_set;
        logic [10:0] set_size;
        logic [10:0] set_count;
        logic        error;
    } uf_result_t;

    logic                          aclk;
    logic                          aresetn       = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [uf_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [uf_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                          cfg_wr_en     = 1'b0;
    logic [uf_pkg::CFG_W-1:0]      cfg_wr_data   = '0;

    // idling controls, changed per traffic phase
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    int unsigned fail_count  = 0;
    int unsigned cycle_count = 0;

    // expected forest state
    logic [9:0]               parent_of  [NODE_CAP];
    logic [10:0]              set_weight [NODE_CAP];
    int unsigned              sets_left;
    int unsigned              active_nodes;
    logic [uf_pkg::CFG_W-1:0] count_reg;

    uf_result_t pending_results[$];

    union_find_engine_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // node count applied by clear, saturated to the table size
    function automatic int unsigned clamp_count(logic [uf_pkg::CFG_W-1:0] v);
        if (v < 2) return 2;
        if (v > NODE_CAP) return NODE_CAP;
        return v;
    endfunction

    function automatic void reset_forest(int unsigned count);
        for (int i = 0; i < NODE_CAP; i++) begin
            parent_of[i]  = i[9:0];
            set_weight[i] = 11'd1;
        end
        active_nodes = count;
        sets_left    = count;
    endfunction

    // walk to the root; only the first PATH_LEN nodes of the walk get relinked
    function automatic logic [9:0] root_with_compression(logic [9:0] x);
        logic [9:0]  walk;
        logic [9:0]  trail [PATH_LEN];
        int unsigned depth;
        int unsigned steps;
        walk  = x;
        depth = 0;
        steps = 0;
        while (parent_of[walk] != walk && steps < NODE_CAP) begin
            if (depth < PATH_LEN) begin
                trail[depth] = walk;
                depth++;
            end
            walk = parent_of[walk];
            steps++;
        end
        for (int i = 0; i < depth; i++) parent_of[trail[i]] = walk;
        return walk;
    endfunction

    // apply one command to the expected forest and return its result
    function automatic uf_result_t resolve_command(uf_pkg::cmd_t op, logic [9:0] a,
                                                   logic [9:0] b);
        uf_result_t r;
        logic [9:0] ra;
        logic [9:0] rb;
        r = '0;
        if (op == uf_pkg::CMD_CLEAR) begin
            reset_forest(clamp_count(count_reg));
        end else if (op == uf_pkg::CMD_UNITE || op == uf_pkg::CMD_QUERY) begin
            if (a >= active_nodes || b >= active_nodes) begin
                r.error = 1'b1;
            end else begin
                ra = root_with_compression(a);
                rb = root_with_compression(b);
                r.same_set = (ra == rb);
                // union by size, first root keeps its place on a tie
                if (op == uf_pkg::CMD_UNITE && ra != rb) begin
                    if (set_weight[ra] >= set_weight[rb]) begin
                        parent_of[rb]  = ra;
                        set_weight[ra] = set_weight[ra] + set_weight[rb];
                        rb = ra;
                    end else begin
                        parent_of[ra]  = rb;
                        set_weight[rb] = set_weight[rb] + set_weight[ra];
                        ra = rb;
                    end
                    if (sets_left != 0) sets_left--;
                    r.merged = 1'b1;
                end
                r.root_a   = ra;
                r.root_b   = rb;
                r.set_size = set_weight[ra];
            end
        end
        r.set_count = sets_left[10:0];
        return r;
    endfunction

    // drive one item, wait for acceptance, record what it should produce
    task automatic send_item(input uf_pkg::cmd_t op, input logic [9:0] a, input logic [9:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{uf_pkg::IN_PAD_W{1'b0}}, b, a, op};
        do @(posedge aclk); while (s_axis_tready !== 1'b1);
        pending_results.push_back(resolve_command(op, a, b));
    endtask

    // hold off the sender until every outstanding result is back
    task automatic wait_all_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    task automatic write_count(input logic [uf_pkg::CFG_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        count_reg    = v;
    endtask

    task automatic set_count_and_clear(input logic [uf_pkg::CFG_W-1:0] v);
        wait_all_results();
        write_count(v);
        send_item(uf_pkg::CMD_CLEAR, 10'($urandom_range(NODE_CAP - 1)),
                  10'($urandom_range(NODE_CAP - 1)));
    endtask

    // unions and queries on the reset table: ties, smaller under larger, no-op
    task automatic test_directed_links();
        send_item(uf_pkg::CMD_UNITE, 10'd0, 10'd1023);
        send_item(uf_pkg::CMD_QUERY, 10'd1023, 10'd0);
        send_item(uf_pkg::CMD_UNITE, 10'd1023, 10'd1023);
        send_item(uf_pkg::CMD_UNITE, 10'd512, 10'd511);
        send_item(uf_pkg::CMD_UNITE, 10'd511, 10'd0);
        send_item(uf_pkg::CMD_UNITE, 10'd5, 10'd1023);
        send_item(uf_pkg::CMD_QUERY, 10'd5, 10'd1);
        send_item(uf_pkg::CMD_NOP, 10'd1023, 10'd1023);
    endtask

    // a new node count only takes hold at the next clear
    task automatic test_latched_count();
        wait_all_results();
        write_count(11'd8);
        send_item(uf_pkg::CMD_QUERY, 10'd100, 10'd200);
        send_item(uf_pkg::CMD_UNITE, 10'd1023, 10'd0);
        send_item(uf_pkg::CMD_CLEAR, 10'd0, 10'd0);
        send_item(uf_pkg::CMD_QUERY, 10'd8, 10'd0);
        send_item(uf_pkg::CMD_QUERY, 10'd0, 10'd8);
        send_item(uf_pkg::CMD_UNITE, 10'd7, 10'd0);
        send_item(uf_pkg::CMD_UNITE, 10'd0, 10'd7);
        send_item(uf_pkg::CMD_NOP, 10'd0, 10'd0);
    endtask

    // register values below, at and above the legal range
    task automatic test_count_limits();
        logic [uf_pkg::CFG_W-1:0] limits [5] = '{11'd0, 11'd2047, 11'd1, 11'd2, 11'd1024};
        recv_stall_pct = 18;
        send_idle_pct  = 18;
        foreach (limits[i]) begin
            set_count_and_clear(limits[i]);
            send_item(uf_pkg::CMD_UNITE, 10'd0, 10'd1);
            send_item(uf_pkg::CMD_QUERY, 10'd1, 10'd1023);
        end
    endtask

    // one clear at a random count, then mostly unions and queries on it
    task automatic random_round(input int unsigned items);
        int unsigned  span;
        int unsigned  pick;
        uf_pkg::cmd_t op;
        logic [9:0]   a;
        logic [9:0]   b;
        pick = $urandom_range(99);
        if (pick < 60)      span = $urandom_range(24, 2);
        else if (pick < 85) span = $urandom_range(200, 25);
        else if (pick < 93) span = $urandom_range(1023, 201);
        else                span = NODE_CAP;
        set_count_and_clear(uf_pkg::CFG_W'(span));
        repeat (items) begin
            pick = $urandom_range(99);
            a = 10'($urandom_range(active_nodes - 1));
            b = 10'($urandom_range(active_nodes - 1));
            if (pick < 58) begin
                op = uf_pkg::CMD_UNITE;
            end else if (pick < 84) begin
                op = uf_pkg::CMD_QUERY;
            end else if (pick < 94) begin
                // node past the active count
                op = ($urandom_range(1) == 1) ? uf_pkg::CMD_UNITE : uf_pkg::CMD_QUERY;
                if (active_nodes < NODE_CAP) begin
                    if ($urandom_range(1) == 1)
                        a = 10'($urandom_range(NODE_CAP - 1, active_nodes));
                    else
                        b = 10'($urandom_range(NODE_CAP - 1, active_nodes));
                end
            end else if (pick < 99) begin
                op = uf_pkg::CMD_NOP;
                a  = 10'($urandom_range(NODE_CAP - 1));
                b  = 10'($urandom_range(NODE_CAP - 1));
            end else begin
                op = uf_pkg::CMD_CLEAR;
            end
            send_item(op, a, b);
        end
    endtask

    // four idling phases, each a run of random rounds
    task automatic test_random_traffic();
        int unsigned send_mix [4] = '{0, 68, 0, 18};
        int unsigned recv_mix [4] = '{0, 0, 68, 18};
        for (int m = 0; m < 4; m++) begin
            send_idle_pct  = send_mix[m];
            recv_stall_pct = recv_mix[m];
            repeat (6) random_round(50);
        end
    endtask

    // result side: random backpressure and in-order compare
    always @(posedge aclk) begin
        uf_result_t got;
        uf_result_t want;
        if (aresetn && m_axis_tvalid === 1'b1 && m_axis_tready) begin
            got.root_a    = m_axis_tdata[9:0];
            got.root_b    = m_axis_tdata[19:10];
            got.merged    = m_axis_tdata[20];
            got.same_set  = m_axis_tdata[21];
            got.set_size  = m_axis_tdata[32:22];
            got.set_count = m_axis_tdata[43:33];
            got.error     = m_axis_tdata[44];
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected item: %p", got);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("mismatch: expected %p, got %p", want, got);
                end
            end
        end
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        count_reg = uf_pkg::CFG_W'(uf_pkg::CFG_RESET);
        reset_forest(uf_pkg::CFG_RESET);
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_links();
        test_latched_count();
        test_count_limits();
        test_random_traffic();
        wait_all_results();
        repeat (64) @(posedge aclk);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
